FILE: rtl/cbm_pkg.sv
// ----------------------------------------------------------------------------
// cbm_pkg
// Types, codes and constants shared by the bank mapper controller, datapath
// and top level.
// ----------------------------------------------------------------------------
package cbm_pkg;

	localparam logic [15:0] CHR_LO        = 16'hA000;
	localparam logic [15:0] CHR_HI        = 16'hDFFF;
	localparam logic [15:0] DECODE_MASK   = 16'hF010;
	localparam logic [15:0] SND_DATA_ADDR = 16'h9030;
	localparam logic [15:0] PRG_LOW_ADDR  = 16'h8000;
	localparam logic [15:0] PRG_MID_ADDR  = 16'h8010;
	localparam logic [15:0] PRG_HIGH_ADDR = 16'h9000;
	localparam logic [15:0] SND_IDX_ADDR  = 16'h9010;
	localparam logic [15:0] MIRROR_ADDR   = 16'hE000;
	localparam logic [15:0] IRQ_LATCH_ADDR = 16'hE010;
	localparam logic [15:0] IRQ_CTRL_ADDR = 16'hF000;
	localparam logic [15:0] IRQ_ACK_ADDR  = 16'hF010;

	localparam int          ACC_W          = 11;
	localparam logic [10:0] PRESCALE_PERIOD = 11'd339;

	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_TICK  = 1'b1;

	typedef struct packed {
		logic        kind;
		logic [15:0] address;
		logic [7:0]  data;
		logic [7:0]  cycles;
	} in_item_t;

	typedef struct packed {
		logic [1:0] irq_pulses;
		logic [7:0] prg_bank_low;
		logic [7:0] prg_bank_mid;
		logic [7:0] prg_bank_high;
		logic [1:0] mirror_mode;
		logic       chr_write_valid;
		logic [2:0] chr_slot;
		logic [7:0] chr_bank;
		logic       sound_write_valid;
		logic [7:0] sound_reg;
		logic [7:0] sound_data;
	} out_item_t;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_RUN
	} ctrl_state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic finish;
	} dp_cmd_t;

	typedef struct packed {
		logic step_pending;
	} dp_status_t;

endpackage

FILE: rtl/cartridge_bank_mapper_cycle_irq.sv
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_cycle_irq
// Cartridge bank mapper with a cycle-driven IRQ counter.
// The result goes to the output register once the transaction is done; a tick
//   with the IRQ enabled first runs its counter steps, at most three.
// One transaction at a time: in_stall stays high until the result is handed
//   on. The single prescaler subtract/step unit runs one step a cycle.
// Reset: asynchronous, clears all mapper and IRQ state; sound enable resets set.
// ----------------------------------------------------------------------------
module cartridge_bank_mapper_cycle_irq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic               cfg_wr_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  cbm_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_stall,
	output cbm_pkg::out_item_t out_item
);
	import cbm_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	cbm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.status    (status)
	);

	cbm_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_item     (in_item),
		.cmd         (cmd),
		.status      (status),
		.out_item    (out_item)
	);

endmodule

FILE: rtl/cbm_ctrl.sv
// ----------------------------------------------------------------------------
// cbm_ctrl
// Sequencer: takes a transaction, runs the prescaler steps one a cycle, then
// hands the result to the output register when it is free.
// ----------------------------------------------------------------------------
module cbm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	output cbm_pkg::dp_cmd_t    cmd,
	input  cbm_pkg::dp_status_t status
);
	import cbm_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_d;
	logic        out_valid_q;
	logic        out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d    = state_q;
		in_stall   = 1'b1;
		cmd        = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_RUN;
				end
			end
			ST_RUN: begin
				if (status.step_pending) begin
					cmd.step = 1'b1;
				end else if (out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

FILE: rtl/cbm_dpath.sv
// ----------------------------------------------------------------------------
// cbm_dpath
// Mapper registers, address decode, IRQ prescaler/counter and the output
// register.
// ----------------------------------------------------------------------------
module cbm_dpath (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic                cfg_wr_data,
	input  cbm_pkg::in_item_t   in_item,
	input  cbm_pkg::dp_cmd_t    cmd,
	output cbm_pkg::dp_status_t status,
	output cbm_pkg::out_item_t  out_item
);
	import cbm_pkg::*;

	// architectural state
	logic [7:0] prg_low_q, prg_mid_q, prg_high_q;
	logic [1:0] mirror_q;
	logic [7:0] snd_idx_q;
	logic [7:0] irq_latch_q;
	logic [7:0] irq_counter_q;
	logic       irq_en_q;
	logic       irq_en_ack_q;
	logic [8:0] prescaler_q;
	logic       snd_en_q;

	// current transaction
	logic             kind_q;
	logic [15:0]      addr_q;
	logic [7:0]       data_q;
	logic [ACC_W-1:0] acc_q;
	logic [1:0]       pulses_q;

	out_item_t out_q;

	// decode
	logic [15:0] m;
	logic [15:0] chr_off;
	logic        is_write, is_chr, is_snd;
	logic [7:0]  prg_low_d, prg_mid_d, prg_high_d, snd_idx_d, irq_latch_d, irq_counter_d;
	logic [1:0]  mirror_d;
	logic        irq_en_d, irq_en_ack_d;
	logic [8:0]  prescaler_d;
	logic        tick_active;
	logic [ACC_W-1:0] acc_init;

	assign tick_active         = (kind_q == KIND_TICK) && irq_en_q;
	assign status.step_pending = tick_active && (acc_q >= PRESCALE_PERIOD);

	assign acc_init = {2'b00, prescaler_q} + {3'b000, in_item.cycles}
		+ {2'b00, in_item.cycles, 1'b0};

	assign m        = addr_q & DECODE_MASK;
	assign chr_off  = m - CHR_LO;
	assign is_write = (kind_q == KIND_WRITE);
	assign is_chr   = is_write && (addr_q >= CHR_LO) && (addr_q <= CHR_HI);
	assign is_snd   = is_write && !is_chr && (addr_q == SND_DATA_ADDR);

	always_comb begin
		prg_low_d     = prg_low_q;
		prg_mid_d     = prg_mid_q;
		prg_high_d    = prg_high_q;
		snd_idx_d     = snd_idx_q;
		mirror_d      = mirror_q;
		irq_latch_d   = irq_latch_q;
		irq_counter_d = irq_counter_q;
		irq_en_d      = irq_en_q;
		irq_en_ack_d  = irq_en_ack_q;
		prescaler_d   = prescaler_q;
		if (tick_active) begin
			prescaler_d = acc_q[8:0];
		end
		if (is_write && !is_chr && !is_snd) begin
			unique case (m)
				PRG_LOW_ADDR:   prg_low_d   = data_q;
				PRG_MID_ADDR:   prg_mid_d   = data_q;
				PRG_HIGH_ADDR:  prg_high_d  = data_q;
				SND_IDX_ADDR:   snd_idx_d   = data_q;
				MIRROR_ADDR:    mirror_d    = data_q[1:0];
				IRQ_LATCH_ADDR: irq_latch_d = data_q;
				IRQ_CTRL_ADDR: begin
					irq_en_d     = data_q[1];
					irq_en_ack_d = data_q[0];
					if (data_q[1]) begin
						irq_counter_d = irq_latch_q;
						prescaler_d   = '0;
					end
				end
				IRQ_ACK_ADDR:   irq_en_d = irq_en_ack_q;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prg_low_q     <= '0;
			prg_mid_q     <= '0;
			prg_high_q    <= '0;
			mirror_q      <= '0;
			snd_idx_q     <= '0;
			irq_latch_q   <= '0;
			irq_counter_q <= '0;
			irq_en_q      <= 1'b0;
			irq_en_ack_q  <= 1'b0;
			prescaler_q   <= '0;
			snd_en_q      <= 1'b1;
		end else begin
			if (cfg_wr_en) begin
				snd_en_q <= cfg_wr_data;
			end
			if (cmd.step) begin
				if (irq_counter_q == 8'hFF) begin
					irq_counter_q <= irq_latch_q;
				end else begin
					irq_counter_q <= irq_counter_q + 8'd1;
				end
			end else if (cmd.finish) begin
				prg_low_q     <= prg_low_d;
				prg_mid_q     <= prg_mid_d;
				prg_high_q    <= prg_high_d;
				mirror_q      <= mirror_d;
				snd_idx_q     <= snd_idx_d;
				irq_latch_q   <= irq_latch_d;
				irq_counter_q <= irq_counter_d;
				irq_en_q      <= irq_en_d;
				irq_en_ack_q  <= irq_en_ack_d;
				prescaler_q   <= prescaler_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q   <= in_item.kind;
			addr_q   <= in_item.address | {11'b0, in_item.address[3], 4'b0};
			data_q   <= in_item.data;
			acc_q    <= acc_init;
			pulses_q <= '0;
		end else if (cmd.step) begin
			acc_q <= acc_q - PRESCALE_PERIOD;
			if (irq_counter_q == 8'hFF) begin
				pulses_q <= pulses_q + 2'd1;
			end
		end
		if (cmd.finish) begin
			out_q.irq_pulses        <= pulses_q;
			out_q.prg_bank_low      <= prg_low_d;
			out_q.prg_bank_mid      <= prg_mid_d;
			out_q.prg_bank_high     <= prg_high_d;
			out_q.mirror_mode       <= mirror_d;
			out_q.chr_write_valid   <= is_chr;
			out_q.chr_slot          <= is_chr ? (chr_off[13:11] | {2'b00, m[4]}) : 3'd0;
			out_q.chr_bank          <= is_chr ? data_q : 8'd0;
			out_q.sound_write_valid <= is_snd && snd_en_q;
			out_q.sound_reg         <= (is_snd && snd_en_q) ? snd_idx_q : 8'd0;
			out_q.sound_data        <= (is_snd && snd_en_q) ? data_q : 8'd0;
		end
	end

	assign out_item = out_q;

endmodule

FILE: rtl/cbm_checker.sv
// ----------------------------------------------------------------------------
// cbm_checker
// Port-level checks on the mapper result channel.
// ----------------------------------------------------------------------------
module cbm_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_stall,
	input cbm_pkg::out_item_t out_item
);
	import cbm_pkg::*;

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_hold_item: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_item))
		else $error("result changed while stalled");

	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_item.chr_write_valid && out_item.sound_write_valid))
		else $error("pattern and sound write in one transaction");

	a_snd_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.sound_write_valid |->
			out_item.sound_reg == 8'd0 && out_item.sound_data == 8'd0)
		else $error("sound fields not cleared");

	a_chr_no_irq: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.chr_write_valid |-> out_item.irq_pulses == 2'd0)
		else $error("IRQ pulse on a bus write");

endmodule

bind cartridge_bank_mapper_cycle_irq cbm_checker u_cbm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_item  (out_item)
);
